// File: rtl/rgo_pkg.sv
// ----------------------------------------------------------------------------
// rgo_pkg
// Shared types and constants for the radial gradient overlay core.
// ----------------------------------------------------------------------------
package rgo_pkg;

  // field widths
  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int CH_W   = 8;
  localparam int COL_W  = 32;
  localparam int DEN_W  = 2 * DIM_W + 1;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int RATIO_BITS_DEF = 16;

  // register reset values
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  // register index in the map
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_INNER  = 2'd2,
    REG_OUTER  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic            drawn;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } result_t;

endpackage

// File: rtl/rgo_div_cell.sv
// ----------------------------------------------------------------------------
// rgo_div_cell
// One restoring long-division step: shifts the remainder, subtracts the
// denominator when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module rgo_div_cell #(
  parameter int FRAC_W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_in,
  input  logic                       ok_in,
  input  logic                       whole_in,
  input  logic [rgo_pkg::DEN_W-1:0]  rem_in,
  input  logic [FRAC_W-1:0]          frac_in,
  input  logic [rgo_pkg::DEN_W-1:0]  den,
  output logic                       v_o,
  output logic                       ok_o,
  output logic                       whole_o,
  output logic [rgo_pkg::DEN_W-1:0]  rem_o,
  output logic [FRAC_W-1:0]          frac_o
);
  import rgo_pkg::*;

  logic [DEN_W:0]   rem2;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic             v_r;
  logic             ok_r;
  logic             whole_r;
  logic [DEN_W-1:0] rem_r;
  logic [FRAC_W-1:0] frac_r;

  // trial subtract
  always_comb begin
    rem2 = {rem_in, 1'b0};
    ge   = (rem2 >= {1'b0, den});
    diff = rem2 - {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      ok_r    <= ok_in;
      whole_r <= whole_in;
      rem_r   <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      frac_r  <= {frac_in[FRAC_W-2:0], ge};
    end
  end

  assign v_o     = v_r;
  assign ok_o    = ok_r;
  assign whole_o = whole_r;
  assign rem_o   = rem_r;
  assign frac_o  = frac_r;

endmodule

// File: rtl/rgo_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rgo_sqrt_cell
// One digit step of the integer square root: tests one result bit against
// the running remainder.
// ----------------------------------------------------------------------------
module rgo_sqrt_cell #(
  parameter int Q_W   = 33,
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_in,
  input  logic           ok_in,
  input  logic [Q_W-1:0] rem_in,
  input  logic [Q_W-1:0] root_in,
  output logic           v_o,
  output logic           ok_o,
  output logic [Q_W-1:0] rem_o,
  output logic [Q_W-1:0] root_o
);
  import rgo_pkg::*;

  localparam logic [Q_W:0] BIT = (Q_W+1)'(1) << SHIFT;

  logic [Q_W:0]   trial;
  logic           fits;
  logic [Q_W:0]   rem_sub;
  logic [Q_W:0]   root_add;
  logic           v_r;
  logic           ok_r;
  logic [Q_W-1:0] rem_r;
  logic [Q_W-1:0] root_r;

  // trial compare
  always_comb begin
    trial    = {1'b0, root_in} + BIT;
    fits     = ({1'b0, rem_in} >= trial);
    rem_sub  = {1'b0, rem_in} - trial;
    root_add = {2'b0, root_in[Q_W-1:1]} + BIT;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      ok_r   <= ok_in;
      rem_r  <= fits ? rem_sub[Q_W-1:0] : rem_in;
      root_r <= fits ? root_add[Q_W-1:0] : {1'b0, root_in[Q_W-1:1]};
    end
  end

  assign v_o    = v_r;
  assign ok_o   = ok_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// File: rtl/radial_gradient_overlay_core.sv
// ----------------------------------------------------------------------------
// radial_gradient_overlay_core
// Radial gradient vignette: one pixel coordinate in, one RGBA colour out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one pixel coordinate per transaction.
//   out_valid/out_stall/out_data carry the overlay colour and drawn flag.
//   The APB port sets image size and the inner and outer colours; write it
//   only while no transaction is in flight.
// Pipeline:
//   three setup stages, 2*RATIO_BITS division cells, RATIO_BITS+1
//   square-root cells and the blend/output register.
//   throughput is one transaction per cycle while out_stall is low; every
//   cell passes its data to the next one each cycle unless it holds for
//   a stall.
// Stall:
//   each stage holds while the one after it is full and stalled, so empty
//   stages keep filling while out_stall is high; in_stall rises only once
//   the whole chain is full.
// Reset:
//   rst_n empties the chain and loads 640x480 with black colours.
// ----------------------------------------------------------------------------
module radial_gradient_overlay_core #(
  parameter int COORD_BITS = rgo_pkg::COORD_BITS_DEF,
  parameter int RATIO_BITS = rgo_pkg::RATIO_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rgo_pkg::pixel_t             in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rgo_pkg::result_t            out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rgo_pkg::ADDR_W-1:0]  paddr,
  input  logic [rgo_pkg::DATA_W-1:0]  pwdata,
  output logic [rgo_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rgo_pkg::*;

  localparam int XW     = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam int FRAC_W = 2 * RATIO_BITS;
  localparam int Q_W    = FRAC_W + 1;
  localparam int R_W    = RATIO_BITS + 1;
  localparam int NSQ    = RATIO_BITS + 1;
  localparam int NST    = 3 + FRAC_W + NSQ;
  localparam int P_W    = CH_W + 2 + R_W;
  localparam logic [R_W-1:0] ONE = R_W'(1) << RATIO_BITS;

  // ---------------- configuration registers ----------------
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [COL_W-1:0] inner_r;
  logic [COL_W-1:0] outer_r;
  logic [DEN_W-1:0] den_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      inner_r  <= '0;
      outer_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_INNER:  inner_r  <= pwdata[COL_W-1:0];
        REG_OUTER:  outer_r  <= pwdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_INNER:  prdata = DATA_W'(inner_r);
      REG_OUTER:  prdata = DATA_W'(outer_r);
      default:    prdata = '0;
    endcase
  end

  // squared diagonal, w*w + h*h (four times the squared centre-to-corner distance)
  always_ff @(posedge clk) begin
    den_r <= DEN_W'(width_r) * DEN_W'(width_r) + DEN_W'(height_r) * DEN_W'(height_r);
  end

  // ---------------- flow control ----------------
  logic [NST:0] vld;
  logic [NST:0] rdy;

  assign rdy[NST] = ~vld[NST] | ~out_stall;
  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = ~vld[i] | rdy[i+1];
  end
  assign in_stall = ~rdy[0];

  // ---------------- stage 0: bounds and offsets ----------------
  logic [PIX_W-1:0] px;
  logic [PIX_W-1:0] py;
  logic [PIX_W-1:0] cx;
  logic [PIX_W-1:0] cy;
  logic             s0_v_r;
  logic             s0_ok_r;
  logic [PIX_W-1:0] s0_dx_r;
  logic [PIX_W-1:0] s0_dy_r;

  always_comb begin
    px = PIX_W'(in_data.pixel_x[XW-1:0]);
    py = PIX_W'(in_data.pixel_y[XW-1:0]);
    cx = width_r[DIM_W-1:1];
    cy = height_r[DIM_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (rdy[0]) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_ok_r <= ({1'b0, px} < width_r) && ({1'b0, py} < height_r);
      s0_dx_r <= (px >= cx) ? px - cx : cx - px;
      s0_dy_r <= (py >= cy) ? py - cy : cy - py;
    end
  end

  // ---------------- stage 1: squares ----------------
  logic                 s1_v_r;
  logic                 s1_ok_r;
  logic [2*PIX_W-1:0]   s1_dxsq_r;
  logic [2*PIX_W-1:0]   s1_dysq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy[1]) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_ok_r   <= s0_ok_r;
      s1_dxsq_r <= s0_dx_r * s0_dx_r;
      s1_dysq_r <= s0_dy_r * s0_dy_r;
    end
  end

  // ---------------- stage 2: numerator and range check ----------------
  logic [DEN_W-1:0] num;
  logic             s2_v_r;
  logic             s2_ok_r;
  logic             s2_whole_r;
  logic [DEN_W-1:0] s2_rem_r;

  assign num = {(DEN_W-2)'({1'b0, s1_dxsq_r} + {1'b0, s1_dysq_r}), 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy[2]) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_ok_r    <= s1_ok_r && (den_r != '0) && (num <= den_r);
      s2_whole_r <= (num == den_r);
      s2_rem_r   <= (s1_ok_r && (num < den_r)) ? num : '0;
    end
  end

  assign vld[0] = s0_v_r;
  assign vld[1] = s1_v_r;
  assign vld[2] = s2_v_r;

  // ---------------- division chain ----------------
  logic             d_v     [0:FRAC_W];
  logic             d_ok    [0:FRAC_W];
  logic             d_whole [0:FRAC_W];
  logic [DEN_W-1:0] d_rem   [0:FRAC_W];
  logic [FRAC_W-1:0] d_frac [0:FRAC_W];

  assign d_v[0]     = s2_v_r;
  assign d_ok[0]    = s2_ok_r;
  assign d_whole[0] = s2_whole_r;
  assign d_rem[0]   = s2_rem_r;
  assign d_frac[0]  = '0;

  for (genvar i = 0; i < FRAC_W; i++) begin : g_div
    rgo_div_cell #(
      .FRAC_W (FRAC_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (rdy[3+i]),
      .v_in     (d_v[i]),
      .ok_in    (d_ok[i]),
      .whole_in (d_whole[i]),
      .rem_in   (d_rem[i]),
      .frac_in  (d_frac[i]),
      .den      (den_r),
      .v_o      (d_v[i+1]),
      .ok_o     (d_ok[i+1]),
      .whole_o  (d_whole[i+1]),
      .rem_o    (d_rem[i+1]),
      .frac_o   (d_frac[i+1])
    );
    assign vld[3+i] = d_v[i+1];
  end

  // ---------------- square root chain ----------------
  logic           q_v    [0:NSQ];
  logic           q_ok   [0:NSQ];
  logic [Q_W-1:0] q_rem  [0:NSQ];
  logic [Q_W-1:0] q_root [0:NSQ];

  assign q_v[0]    = d_v[FRAC_W];
  assign q_ok[0]   = d_ok[FRAC_W];
  assign q_rem[0]  = {d_whole[FRAC_W], d_frac[FRAC_W]};
  assign q_root[0] = '0;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    rgo_sqrt_cell #(
      .Q_W   (Q_W),
      .SHIFT (2 * (RATIO_BITS - j))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (rdy[3+FRAC_W+j]),
      .v_in    (q_v[j]),
      .ok_in   (q_ok[j]),
      .rem_in  (q_rem[j]),
      .root_in (q_root[j]),
      .v_o     (q_v[j+1]),
      .ok_o    (q_ok[j+1]),
      .rem_o   (q_rem[j+1]),
      .root_o  (q_root[j+1])
    );
    assign vld[3+FRAC_W+j] = q_v[j+1];
  end

  // ---------------- blend and output register ----------------
  logic [R_W-1:0] ratio;
  result_t        res;
  logic           out_valid_r;
  result_t        out_data_r;

  // one channel: inner + floor(ratio*(outer-inner) / 2^RATIO_BITS)
  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic [R_W-1:0]  r);
    logic signed [CH_W+1:0] diff;
    logic signed [P_W-1:0]  prod;
    logic signed [P_W-1:0]  step;
    logic [P_W-1:0]         sum;
    diff = $signed({2'b00, b}) - $signed({2'b00, a});
    prod = P_W'(diff) * $signed(P_W'({1'b0, r}));
    step = prod >>> RATIO_BITS;
    sum  = P_W'(a) + P_W'(step);
    return sum[CH_W-1:0];
  endfunction

  always_comb begin
    ratio = (q_root[NSQ] > Q_W'(ONE)) ? ONE : q_root[NSQ][R_W-1:0];
    res.drawn = q_ok[NSQ];
    res.red   = blend_ch(inner_r[7:0],   outer_r[7:0],   ratio);
    res.green = blend_ch(inner_r[15:8],  outer_r[15:8],  ratio);
    res.blue  = blend_ch(inner_r[23:16], outer_r[23:16], ratio);
    res.alpha = blend_ch(inner_r[31:24], outer_r[31:24], ratio);
    if (!q_ok[NSQ]) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NST]) begin
      out_valid_r <= q_v[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      out_data_r <= res;
    end
  end

  assign vld[NST]  = out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  // a pixel not drawn carries a black, transparent colour
  a_undrawn_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.drawn |->
      out_data.red == '0 && out_data.green == '0 &&
      out_data.blue == '0 && out_data.alpha == '0)
    else $error("undrawn pixel has nonzero colour");

  // a new result only appears when the last cell held an item
  a_out_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(q_v[NSQ]))
    else $error("result appeared from an empty chain");

  // square root of a value at most one never exceeds one
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_v[NSQ] && q_ok[NSQ] |-> q_root[NSQ] <= Q_W'(ONE))
    else $error("ratio above one");

  // the input is held back only when the first stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_v_r)
    else $error("input stalled with an empty first stage");

endmodule
